// ===== design/mofu_pkg.sv =====
// shared types and constants for the multiplicative order finder
package mofu_pkg;

  // operand width; arithmetic products need twice this width
  localparam int WIDTH = 32;
  // width of the external operand and order ports
  localparam int IO_W = 32;
  // divider step counter covers one step per dividend bit
  localparam int CNT_W = $clog2(2 * WIDTH);

  typedef logic [WIDTH-1:0]   word_t;
  typedef logic [2*WIDTH-1:0] dword_t;
  typedef logic [IO_W-1:0]    io_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_NOT_COPRIME = 2'd1,
    ST_INVALID     = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED,
    S_GCD,
    S_GCDW,
    S_TSQ,
    S_TCMP,
    S_TDIV,
    S_TPHD,
    S_TPHM,
    S_TPHU,
    S_TTAIL,
    S_TTLD,
    S_TTLM,
    S_TTLU,
    S_OINIT,
    S_OSQ,
    S_OCMP,
    S_ODIV,
    S_SBEG,
    S_SDIV,
    S_SEND,
    S_PCHK,
    S_PAM,
    S_PAD,
    S_PADW,
    S_PSM,
    S_PSD,
    S_PSDW
  } state_t;

  // request to the shared divider
  typedef struct packed {
    logic   start;
    dword_t dividend;
    word_t  divisor;
  } div_req_t;

  // divider result, held until the next request
  typedef struct packed {
    logic   done;
    dword_t quot;
    word_t  rem;
  } div_res_t;

endpackage

// ===== design/mofu_div.sv =====
// restoring divider, one quotient bit per cycle, double-width dividend
module mofu_div (
  input  logic               clk,
  input  logic               rst,
  input  mofu_pkg::div_req_t req,
  output mofu_pkg::div_res_t res
);

  logic                          running;
  logic                          done;
  mofu_pkg::cnt_t                cnt;
  mofu_pkg::dword_t              work;
  mofu_pkg::dword_t              work_next;
  mofu_pkg::word_t               rem;
  mofu_pkg::word_t               rem_next;
  mofu_pkg::word_t               dsr;
  logic [mofu_pkg::WIDTH:0]      trial;
  logic [mofu_pkg::WIDTH:0]      diff;

  always_comb begin
    trial = {rem, work[2*mofu_pkg::WIDTH-1]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      rem_next  = mofu_pkg::word_t'(diff);
      work_next = {work[2*mofu_pkg::WIDTH-2:0], 1'b1};
    end else begin
      rem_next  = mofu_pkg::word_t'(trial);
      work_next = {work[2*mofu_pkg::WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= mofu_pkg::cnt_t'(2 * mofu_pkg::WIDTH - 1);
        work    <= req.dividend;
        rem     <= '0;
        dsr     <= req.divisor;
      end else if (running) begin
        work <= work_next;
        rem  <= rem_next;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - mofu_pkg::cnt_t'(1);
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = work;
  assign res.rem  = rem;

endmodule

// ===== design/multiplicative_order_finder_unit.sv =====
// multiplicative order finder: sequencer around one divider and one multiplier
//
//   channel   direction  signals                  transfer
//   command   in         start, modulus, base     start high while busy low
//   result    out        done, order, status      done high for one cycle
//
// operation: result the cycle after acceptance for modulus zero or one, else data
//   dependent; each modulo runs on the shared divider, totient and order search
//   trial-divide up to sqrt(n), and each strip test is up to 2*WIDTH
//   multiply-divide rounds
// reset: synchronous, clears the sequencer and the result strobe; no memory
// stalls: busy high from acceptance through the done cycle; no receiver stall
module multiplicative_order_finder_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mofu_pkg::io_t modulus,
  input  mofu_pkg::io_t base,
  output logic          busy,
  output logic          done,
  output mofu_pkg::io_t order,
  output logic [1:0]    status
);

  mofu_pkg::state_t   state, state_next;

  // operands and working values of the search
  mofu_pkg::word_t    n, n_next;
  mofu_pkg::word_t    a, a_next;
  mofu_pkg::word_t    x, x_next;
  mofu_pkg::word_t    y, y_next;
  mofu_pkg::word_t    t, t_next;
  mofu_pkg::word_t    phi, phi_next;
  mofu_pkg::word_t    p, p_next;
  mofu_pkg::word_t    k, k_next;
  mofu_pkg::word_t    f, f_next;
  mofu_pkg::word_t    q, q_next;
  mofu_pkg::word_t    sf, sf_next;
  mofu_pkg::word_t    e, e_next;
  mofu_pkg::word_t    cand, cand_next;
  mofu_pkg::word_t    acc, acc_next;
  mofu_pkg::word_t    sq, sq_next;
  mofu_pkg::word_t    ma, ma_next;
  mofu_pkg::word_t    mb, mb_next;
  mofu_pkg::dword_t   prod;
  logic               hit, hit_next;
  logic               tail, tail_next;

  // result register
  logic               done_r, done_next;
  mofu_pkg::word_t    order_r, order_next;
  logic [1:0]         status_r, status_next;

  mofu_pkg::div_req_t div_req;
  mofu_pkg::div_res_t div_res;

  mofu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  always_comb begin
    state_next  = state;
    n_next      = n;
    a_next      = a;
    x_next      = x;
    y_next      = y;
    t_next      = t;
    phi_next    = phi;
    p_next      = p;
    k_next      = k;
    f_next      = f;
    q_next      = q;
    sf_next     = sf;
    e_next      = e;
    cand_next   = cand;
    acc_next    = acc;
    sq_next     = sq;
    ma_next     = ma;
    mb_next     = mb;
    hit_next    = hit;
    tail_next   = tail;
    done_next   = 1'b0;
    order_next  = order_r;
    status_next = status_r;

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = n;

    case (state)
      mofu_pkg::S_IDLE: begin
        // no new transaction while the previous result is still strobed
        if (start && !busy) begin
          n_next = mofu_pkg::word_t'(modulus);
          a_next = mofu_pkg::word_t'(base);
          if (mofu_pkg::word_t'(modulus) == '0) begin
            done_next   = 1'b1;
            order_next  = '0;
            status_next = mofu_pkg::ST_INVALID;
          end else if (mofu_pkg::word_t'(modulus) == mofu_pkg::word_t'(1)) begin
            // every base is a unit modulo one
            done_next   = 1'b1;
            order_next  = mofu_pkg::word_t'(1);
            status_next = mofu_pkg::ST_FOUND;
          end else begin
            // reduce the base modulo n
            div_req.start    = 1'b1;
            div_req.dividend = mofu_pkg::dword_t'(mofu_pkg::word_t'(base));
            div_req.divisor  = mofu_pkg::word_t'(modulus);
            state_next       = mofu_pkg::S_RED;
          end
        end
      end

      mofu_pkg::S_RED: begin
        if (div_res.done) begin
          a_next     = div_res.rem;
          x_next     = n;
          y_next     = div_res.rem;
          state_next = mofu_pkg::S_GCD;
        end
      end

      // euclid: x, y <- y, x mod y
      mofu_pkg::S_GCD: begin
        if (y == '0) begin
          if (x == mofu_pkg::word_t'(1)) begin
            t_next     = n;
            phi_next   = n;
            p_next     = mofu_pkg::word_t'(2);
            ma_next    = mofu_pkg::word_t'(2);
            mb_next    = mofu_pkg::word_t'(2);
            state_next = mofu_pkg::S_TSQ;
          end else begin
            done_next   = 1'b1;
            order_next  = '0;
            status_next = mofu_pkg::ST_NOT_COPRIME;
            state_next  = mofu_pkg::S_IDLE;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = mofu_pkg::dword_t'(x);
          div_req.divisor  = y;
          state_next       = mofu_pkg::S_GCDW;
        end
      end

      mofu_pkg::S_GCDW: begin
        if (div_res.done) begin
          x_next     = y;
          y_next     = div_res.rem;
          state_next = mofu_pkg::S_GCD;
        end
      end

      // totient by trial division, p*p formed in the multiplier
      mofu_pkg::S_TSQ: state_next = mofu_pkg::S_TCMP;

      mofu_pkg::S_TCMP: begin
        if (prod > mofu_pkg::dword_t'(t)) begin
          state_next = mofu_pkg::S_TTAIL;
        end else begin
          hit_next         = 1'b0;
          div_req.start    = 1'b1;
          div_req.dividend = mofu_pkg::dword_t'(t);
          div_req.divisor  = p;
          state_next       = mofu_pkg::S_TDIV;
        end
      end

      mofu_pkg::S_TDIV: begin
        if (div_res.done) begin
          if (div_res.rem == '0) begin
            t_next = mofu_pkg::word_t'(div_res.quot);
            if (!hit) begin
              // first hit on this prime: phi = phi / p * (p - 1)
              hit_next         = 1'b1;
              div_req.start    = 1'b1;
              div_req.dividend = mofu_pkg::dword_t'(phi);
              div_req.divisor  = p;
              state_next       = mofu_pkg::S_TPHD;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = div_res.quot;
              div_req.divisor  = p;
            end
          end else begin
            p_next     = p + mofu_pkg::word_t'(1);
            ma_next    = p + mofu_pkg::word_t'(1);
            mb_next    = p + mofu_pkg::word_t'(1);
            state_next = mofu_pkg::S_TSQ;
          end
        end
      end

      mofu_pkg::S_TPHD: begin
        if (div_res.done) begin
          ma_next    = mofu_pkg::word_t'(div_res.quot);
          mb_next    = p - mofu_pkg::word_t'(1);
          state_next = mofu_pkg::S_TPHM;
        end
      end

      mofu_pkg::S_TPHM: state_next = mofu_pkg::S_TPHU;

      mofu_pkg::S_TPHU: begin
        phi_next         = mofu_pkg::word_t'(prod);
        div_req.start    = 1'b1;
        div_req.dividend = mofu_pkg::dword_t'(t);
        div_req.divisor  = p;
        state_next       = mofu_pkg::S_TDIV;
      end

      // leftover prime factor of n
      mofu_pkg::S_TTAIL: begin
        if (t > mofu_pkg::word_t'(1)) begin
          div_req.start    = 1'b1;
          div_req.dividend = mofu_pkg::dword_t'(phi);
          div_req.divisor  = t;
          state_next       = mofu_pkg::S_TTLD;
        end else begin
          state_next = mofu_pkg::S_OINIT;
        end
      end

      mofu_pkg::S_TTLD: begin
        if (div_res.done) begin
          ma_next    = mofu_pkg::word_t'(div_res.quot);
          mb_next    = t - mofu_pkg::word_t'(1);
          state_next = mofu_pkg::S_TTLM;
        end
      end

      mofu_pkg::S_TTLM: state_next = mofu_pkg::S_TTLU;

      mofu_pkg::S_TTLU: begin
        phi_next   = mofu_pkg::word_t'(prod);
        state_next = mofu_pkg::S_OINIT;
      end

      // order search: k starts at phi, strip each prime factor q of phi
      mofu_pkg::S_OINIT: begin
        k_next     = phi;
        f_next     = phi;
        q_next     = mofu_pkg::word_t'(2);
        ma_next    = mofu_pkg::word_t'(2);
        mb_next    = mofu_pkg::word_t'(2);
        state_next = mofu_pkg::S_OSQ;
      end

      mofu_pkg::S_OSQ: state_next = mofu_pkg::S_OCMP;

      mofu_pkg::S_OCMP: begin
        if (prod > mofu_pkg::dword_t'(f)) begin
          if (f > mofu_pkg::word_t'(1)) begin
            sf_next    = f;
            tail_next  = 1'b1;
            state_next = mofu_pkg::S_SBEG;
          end else begin
            done_next   = 1'b1;
            order_next  = k;
            status_next = mofu_pkg::ST_FOUND;
            state_next  = mofu_pkg::S_IDLE;
          end
        end else begin
          hit_next         = 1'b0;
          div_req.start    = 1'b1;
          div_req.dividend = mofu_pkg::dword_t'(f);
          div_req.divisor  = q;
          state_next       = mofu_pkg::S_ODIV;
        end
      end

      mofu_pkg::S_ODIV: begin
        if (div_res.done) begin
          if (div_res.rem == '0) begin
            f_next           = mofu_pkg::word_t'(div_res.quot);
            hit_next         = 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = div_res.quot;
            div_req.divisor  = q;
          end else if (hit) begin
            sf_next    = q;
            tail_next  = 1'b0;
            state_next = mofu_pkg::S_SBEG;
          end else begin
            q_next     = q + mofu_pkg::word_t'(1);
            ma_next    = q + mofu_pkg::word_t'(1);
            mb_next    = q + mofu_pkg::word_t'(1);
            state_next = mofu_pkg::S_OSQ;
          end
        end
      end

      // strip one factor sf from k while a^(k/sf) mod n stays one
      mofu_pkg::S_SBEG: begin
        div_req.start    = 1'b1;
        div_req.dividend = mofu_pkg::dword_t'(k);
        div_req.divisor  = sf;
        state_next       = mofu_pkg::S_SDIV;
      end

      mofu_pkg::S_SDIV: begin
        if (div_res.done) begin
          if (div_res.rem != '0) begin
            state_next = mofu_pkg::S_SEND;
          end else begin
            cand_next  = mofu_pkg::word_t'(div_res.quot);
            e_next     = mofu_pkg::word_t'(div_res.quot);
            acc_next   = mofu_pkg::word_t'(1);
            sq_next    = a;
            state_next = mofu_pkg::S_PCHK;
          end
        end
      end

      mofu_pkg::S_SEND: begin
        if (tail) begin
          done_next   = 1'b1;
          order_next  = k;
          status_next = mofu_pkg::ST_FOUND;
          state_next  = mofu_pkg::S_IDLE;
        end else begin
          q_next     = q + mofu_pkg::word_t'(1);
          ma_next    = q + mofu_pkg::word_t'(1);
          mb_next    = q + mofu_pkg::word_t'(1);
          state_next = mofu_pkg::S_OSQ;
        end
      end

      // square-and-multiply, lsb first
      mofu_pkg::S_PCHK: begin
        if (e == '0) begin
          if (acc == mofu_pkg::word_t'(1)) begin
            k_next     = cand;
            state_next = mofu_pkg::S_SBEG;
          end else begin
            state_next = mofu_pkg::S_SEND;
          end
        end else if (e[0]) begin
          ma_next    = acc;
          mb_next    = sq;
          state_next = mofu_pkg::S_PAM;
        end else begin
          ma_next    = sq;
          mb_next    = sq;
          state_next = mofu_pkg::S_PSM;
        end
      end

      mofu_pkg::S_PAM: state_next = mofu_pkg::S_PAD;

      mofu_pkg::S_PAD: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod;
        div_req.divisor  = n;
        state_next       = mofu_pkg::S_PADW;
      end

      mofu_pkg::S_PADW: begin
        if (div_res.done) begin
          acc_next   = div_res.rem;
          ma_next    = sq;
          mb_next    = sq;
          state_next = mofu_pkg::S_PSM;
        end
      end

      mofu_pkg::S_PSM: state_next = mofu_pkg::S_PSD;

      mofu_pkg::S_PSD: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod;
        div_req.divisor  = n;
        state_next       = mofu_pkg::S_PSDW;
      end

      mofu_pkg::S_PSDW: begin
        if (div_res.done) begin
          sq_next    = div_res.rem;
          e_next     = e >> 1;
          state_next = mofu_pkg::S_PCHK;
        end
      end

      default: state_next = mofu_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mofu_pkg::S_IDLE;
      done_r <= 1'b0;
      hit    <= 1'b0;
      tail   <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= done_next;
      hit    <= hit_next;
      tail   <= tail_next;
    end
  end

  // datapath registers, shared multiplier with registered product
  always_ff @(posedge clk) begin
    n        <= n_next;
    a        <= a_next;
    x        <= x_next;
    y        <= y_next;
    t        <= t_next;
    phi      <= phi_next;
    p        <= p_next;
    k        <= k_next;
    f        <= f_next;
    q        <= q_next;
    sf       <= sf_next;
    e        <= e_next;
    cand     <= cand_next;
    acc      <= acc_next;
    sq       <= sq_next;
    ma       <= ma_next;
    mb       <= mb_next;
    prod     <= mofu_pkg::dword_t'(ma) * mofu_pkg::dword_t'(mb);
    order_r  <= order_next;
    status_r <= status_next;
  end

  assign busy   = (state != mofu_pkg::S_IDLE) || done_r;
  assign done   = done_r;
  assign order  = mofu_pkg::io_t'(order_r);
  assign status = status_r;

endmodule

// ===== test/multiplicative_order_finder_unit_test.sv =====
// self-checking testbench for the multiplicative order finder unit
`timescale 1ns / 100ps

module multiplicative_order_finder_unit_test;
  import mofu_pkg::*;

  // one expected result per accepted transaction
  typedef struct {
    io_t     order;
    status_t status;
  } order_result_t;

  // keeps the pending orders and checks each result against the oldest one
  class order_scoreboard;
    order_result_t expected_q[$];
    int errors;
    int checked;
    int n_found;
    int n_not_coprime;
    int n_invalid;
    word_t widest_modulus;

    function word_t gcd_word(word_t x, word_t y);
      word_t r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    // square and multiply, products kept in double width
    function word_t mod_power(word_t x, word_t e, word_t m);
      dword_t acc;
      dword_t sq;
      acc = (m == 1) ? dword_t'(0) : dword_t'(1);
      sq = dword_t'(x % m);
      while (e != 0) begin
        if (e[0]) begin
          acc = (acc * sq) % m;
        end
        sq = (sq * sq) % m;
        e = e >> 1;
      end
      return word_t'(acc);
    endfunction

    function word_t euler_phi(word_t n);
      dword_t p;
      word_t t;
      word_t phi;
      t = n;
      phi = n;
      for (p = 2; p * p <= t; p++) begin
        if (t % word_t'(p) == 0) begin
          phi = phi / word_t'(p) * (word_t'(p) - 1);
          while (t % word_t'(p) == 0) begin
            t = t / word_t'(p);
          end
        end
      end
      if (t > 1) begin
        phi = phi / t * (t - 1);
      end
      return phi;
    endfunction

    // divide q out of the candidate while the power still gives one
    function word_t strip_prime(word_t k, word_t q, word_t a, word_t n);
      while (k % q == 0 && mod_power(a, k / q, n) == 1) begin
        k = k / q;
      end
      return k;
    endfunction

    function word_t order_of(word_t a, word_t n);
      word_t k;
      word_t f;
      dword_t q;
      k = euler_phi(n);
      f = k;
      for (q = 2; q * q <= f; q++) begin
        if (f % word_t'(q) == 0) begin
          while (f % word_t'(q) == 0) begin
            f = f / word_t'(q);
          end
          k = strip_prime(k, word_t'(q), a, n);
        end
      end
      if (f > 1) begin
        k = strip_prime(k, f, a, n);
      end
      return k;
    endfunction

    function void note_command(io_t cmd_modulus, io_t cmd_base);
      order_result_t want;
      word_t n;
      word_t a;
      n = cmd_modulus[WIDTH-1:0];
      a = cmd_base[WIDTH-1:0];
      want.order = '0;
      if (n > widest_modulus) begin
        widest_modulus = n;
      end
      if (n == 0) begin
        want.status = ST_INVALID;
      end else if (n == 1) begin
        want.order = 1;
        want.status = ST_FOUND;
      end else begin
        a = a % n;
        if (gcd_word(n, a) != 1) begin
          want.status = ST_NOT_COPRIME;
        end else begin
          want.order = order_of(a, n);
          want.status = ST_FOUND;
        end
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(io_t got_order, logic [1:0] got_status);
      order_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: order %0d status %0d", got_order, got_status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got_order !== want.order) begin
        $error("order mismatch: expected %0d, got %0d", want.order, got_order);
        errors++;
      end
      if (got_status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got_status);
        errors++;
      end
      case (want.status)
        ST_FOUND: n_found++;
        ST_NOT_COPRIME: n_not_coprime++;
        default: n_invalid++;
      endcase
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  io_t        modulus;
  io_t        base;
  logic       busy;
  logic       done;
  io_t        order;
  logic [1:0] status;

  order_scoreboard sb = new();

  // chance in percent that the sender holds back in a given cycle
  int sender_idle_pct;
  int sent;

  multiplicative_order_finder_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .modulus(modulus),
    .base(base),
    .busy(busy),
    .done(done),
    .order(order),
    .status(status)
  );

  // 4 ns clock period
  always #2 clk = ~clk;

  // result monitor: done is sampled before the edge updates it, so the
  // result fields seen here are the ones of the strobed cycle
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(order, status);
    end
  end

  // drives one transaction; while idling, the operand ports carry noise with
  // start low. the transaction goes in at the edge where start is high and
  // busy is low, and start drops at the following falling edge so that the
  // same operands are never taken twice
  task automatic send_command(input io_t cmd_modulus, input io_t cmd_base);
    bit accepted;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      if ($urandom_range(99) < sender_idle_pct) begin
        start <= 1'b0;
        modulus <= $urandom;
        base <= $urandom;
      end else begin
        start <= 1'b1;
        modulus <= cmd_modulus;
        base <= cmd_base;
      end
      @(posedge clk);
      if (start && !busy) begin
        accepted = 1'b1;
        sb.note_command(cmd_modulus, cmd_base);
      end
    end
    @(negedge clk);
    start <= 1'b0;
    sent++;
  endtask

  // picks a base coprime to the modulus where a few draws allow it, so that
  // most transactions get past the gcd check into the order search
  task automatic pick_coprime_base(input io_t cmd_modulus, output io_t cmd_base);
    cmd_base = $urandom;
    repeat (8) begin
      if (sb.gcd_word(cmd_modulus, cmd_base % cmd_modulus) != 1) begin
        cmd_base = $urandom;
      end
    end
  endtask

  // the totient search walks up to the square root of the modulus, so large
  // moduli are built only from factors up to 251 to keep the run short
  task automatic pick_command(output io_t cmd_modulus, output io_t cmd_base);
    int unsigned kind;
    longint unsigned acc;
    int unsigned f;
    bit full;
    kind = $urandom_range(99);
    if (kind < 55) begin
      // small modulus, well-formed
      cmd_modulus = $urandom_range(4095, 2);
      pick_coprime_base(cmd_modulus, cmd_base);
    end else if (kind < 65) begin
      // tiny modulus, well-formed
      cmd_modulus = $urandom_range(31, 2);
      pick_coprime_base(cmd_modulus, cmd_base);
    end else if (kind < 80) begin
      // wide smooth modulus, up to the full 32 bits
      acc = 1;
      full = 1'b0;
      while (!full) begin
        f = $urandom_range(251, 2);
        if (acc * f > 64'hFFFF_FFFF) begin
          full = 1'b1;
        end else begin
          acc = acc * f;
        end
      end
      cmd_modulus = io_t'(acc);
      pick_coprime_base(cmd_modulus, cmd_base);
    end else if (kind < 94) begin
      // small modulus with any base, often not coprime
      cmd_modulus = $urandom_range(4095, 2);
      cmd_base = $urandom;
    end else begin
      // degenerate moduli zero and one
      cmd_modulus = $urandom_range(1, 0);
      cmd_base = $urandom;
    end
  endtask

  task automatic run_random(input int count);
    io_t m;
    io_t b;
    repeat (count) begin
      pick_command(m, b);
      send_command(m, b);
    end
  endtask

  // extremes, degenerate moduli, non-coprime pairs and known orders
  task automatic run_directed();
    send_command(32'd0, 32'd0);
    send_command(32'd0, 32'hFFFF_FFFF);
    send_command(32'd1, 32'd0);
    send_command(32'd1, 32'hFFFF_FFFF);
    send_command(32'd2, 32'd0);
    send_command(32'd2, 32'd1);
    send_command(32'd2, 32'hFFFF_FFFF);
    send_command(32'd7, 32'd8);
    send_command(32'd9, 32'd2);
    send_command(32'd10, 32'd4);
    send_command(32'd10, 32'd10);
    send_command(32'd10, 32'd3);
    send_command(32'd1000, 32'd7);
    send_command(32'd4093, 32'd2);
    send_command(32'd4093, 32'd4092);
    send_command(32'd65537, 32'd3);
    send_command(32'hFFFF_FFFF, 32'd2);
    send_command(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_command(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(32'hFFFF_FFFF, 32'h8000_0000);
    send_command(32'h8000_0000, 32'd3);
    send_command(32'h8000_0000, 32'hFFFF_FFFF);
    send_command(32'h8000_0000, 32'h8000_0000);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    modulus = '0;
    base = '0;
    sent = 0;
    sender_idle_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    // random part in three pacing phases: light sender idling, heavy
    // idling, then back to back
    sender_idle_pct = 12;
    run_random(34);
    sender_idle_pct = 76;
    run_random(33);
    sender_idle_pct = 0;
    run_random(33);

    // drain, then give a stray result time to show up
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("checked %0d of %0d transactions: %0d orders found, %0d not coprime, %0d invalid",
             sb.checked, sent, sb.n_found, sb.n_not_coprime, sb.n_invalid);
    $display("sender idle at 12, 76 and 0 percent; widest modulus 0x%08h",
             sb.widest_modulus);
    if (sb.errors == 0) begin
      $display("[multiplicative_order_finder_unit] OK");
    end else begin
      $display("[multiplicative_order_finder_unit] ERROR");
    end
    $finish;
  end

  // watchdog for a hung search
  initial begin
    #500_000_000;
    $display("[multiplicative_order_finder_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mofu_pkg.sv
design/mofu_div.sv
design/multiplicative_order_finder_unit.sv
test/multiplicative_order_finder_unit_test.sv
